// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; only cexm_seq.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CEXM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CEXM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cexm_pkg.sv -----
package cexm_pkg;

  localparam int MAX_DIM = 8;

  localparam int IW      = $clog2(MAX_DIM);
  localparam int DEPTH_I = MAX_DIM * MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int DEPTH_D = MAX_DIM * MAX_DIM;
  localparam int IAW     = $clog2(DEPTH_I);
  localparam int DAW     = $clog2(DEPTH_D);

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 12;
  localparam int VALUE_W = 32;
  localparam int ROW_W   = 3;
  localparam int RES_W   = 48;
  localparam int ACC_W   = 64;
  localparam int CFG_W   = 4;
  localparam int FRAC_W  = 24;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  typedef enum logic [KIND_W-1:0] {
    KIND_INT  = 2'd0,
    KIND_DEN  = 2'd1,
    KIND_COMP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                     valid;
    logic [KIND_W-1:0]        kind;
    logic [INDEX_W-1:0]       index;
    logic signed [VALUE_W-1:0] value;
  } load_t;

  typedef struct packed {
    logic           valid;
    logic [IAW-1:0] iaddr_j;
    logic [IAW-1:0] iaddr_k;
    logic [DAW-1:0] daddr;
    logic           wj;
    logic           dbl;
  } rd_req_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] data_j;
    logic signed [VALUE_W-1:0] data_k;
    logic signed [VALUE_W-1:0] data_d;
    logic                      wj;
    logic                      dbl;
  } rd_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             last;
  } emit_t;

  function automatic logic [IAW-1:0] iaddr(input logic [IW-1:0] a, input logic [IW-1:0] b,
                                           input logic [IW-1:0] c, input logic [IW-1:0] d);
    int flat;
    flat = ((int'(a) * MAX_DIM + int'(b)) * MAX_DIM + int'(c)) * MAX_DIM + int'(d);
    return IAW'(flat);
  endfunction

  function automatic logic [DAW-1:0] daddr(input logic [IW-1:0] a, input logic [IW-1:0] b);
    int flat;
    flat = int'(a) * MAX_DIM + int'(b);
    return DAW'(flat);
  endfunction

endpackage

// ----- rtl/coulomb_exchange_matrix_build.sv -----
// Builds the lower triangle of the Coulomb (J) and exchange (K) matrices from a
// four-index integral tensor and a density matrix, all in signed Q8.24. A transaction
// with tuser 0 writes one integral element and tuser 1 one density element; while idle,
// the port accepts one per cycle. A transaction with tuser 2 walks p = 0..dim-1 and
// q = 0..p and returns one result transaction per (p,q), J and K in saturated Q24.24,
// with tlast on the final one. For each (p,q) the integral memory serves the J and K
// reads through two read ports, one product pair per cycle, followed by a drain until
// the multiply-accumulate pipeline is empty and an emit once the output register is
// free. The input stays stalled until the whole triangle has been handed to the
// output register. Unwritten entries of either memory read back as unknown values.
module coulomb_exchange_matrix_build (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,   // dim_in_use
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,    // index [11:0], value [43:12], zero fill
  input  logic [1:0]   in_tuser,    // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,   // row, col, coulomb_value, exchange_value, zero fill
  output logic         out_tlast
);
  import cexm_pkg::*;

  logic [CFG_W-1:0]         dim_r;
  logic                     in_acc;
  logic                     start;
  logic                     idle;
  logic                     pipe_busy;
  logic                     out_free;
  load_t                    load;
  rd_req_t                  req;
  rd_rsp_t                  rsp;
  emit_t                    emit;
  logic signed [RES_W-1:0]  coulomb_sat;
  logic signed [RES_W-1:0]  exchange_sat;

  logic                     out_valid_r;
  logic [ROW_W-1:0]         row_r;
  logic [ROW_W-1:0]         col_r;
  logic [RES_W-1:0]         coulomb_r;
  logic [RES_W-1:0]         exchange_r;
  logic                     last_r;

  assign in_tready  = idle;
  assign in_acc     = in_tvalid && in_tready;
  assign start      = in_acc && (in_tuser == KIND_COMP);
  assign out_free   = !out_valid_r || out_tready;

  assign load.valid = in_acc;
  assign load.kind  = in_tuser;
  assign load.index = in_tdata[INDEX_W-1:0];
  assign load.value = in_tdata[INDEX_W+VALUE_W-1:INDEX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_we) begin
      dim_r <= cfg_wdata;
    end
  end

  cexm_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .req   (req),
    .rsp   (rsp)
  );

  cexm_mac u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp          (rsp),
    .acc_clr      (emit.valid),
    .busy         (pipe_busy),
    .coulomb_sat  (coulomb_sat),
    .exchange_sat (exchange_sat)
  );

  cexm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_dim   (dim_r),
    .start     (start),
    .pipe_busy (pipe_busy),
    .out_free  (out_free),
    .idle      (idle),
    .req       (req),
    .emit      (emit)
  );

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      row_r      <= emit.row;
      col_r      <= emit.col;
      coulomb_r  <= coulomb_sat;
      exchange_r <= exchange_sat;
      last_r     <= emit.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {2'b00, exchange_r, coulomb_r, col_r, row_r};

endmodule

// ----- rtl/cexm_store.sv -----
module cexm_store (
  input  logic              clk,
  input  logic              rst_n,
  input  cexm_pkg::load_t   load,
  input  cexm_pkg::rd_req_t req,
  output cexm_pkg::rd_rsp_t rsp
);
  import cexm_pkg::*;

  logic signed [VALUE_W-1:0] imem [DEPTH_I];
  logic signed [VALUE_W-1:0] dmem [DEPTH_D];

  logic    we_i;
  logic    we_d;
  rd_rsp_t rsp_r;

  assign we_i = load.valid && (load.kind == KIND_INT) && (32'(load.index) < DEPTH_I);
  assign we_d = load.valid && (load.kind == KIND_DEN) && (32'(load.index) < DEPTH_D);

  always_ff @(posedge clk) begin
    if (we_i) begin
      imem[load.index[IAW-1:0]] <= load.value;
    end
    if (we_d) begin
      dmem[load.index[DAW-1:0]] <= load.value;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r.data_j <= imem[req.iaddr_j];
    rsp_r.data_k <= imem[req.iaddr_k];
    rsp_r.data_d <= dmem[req.daddr];
    rsp_r.wj     <= req.wj;
    rsp_r.dbl    <= req.dbl;
    if (!rst_n) begin
      rsp_r.valid <= 1'b0;
    end else begin
      rsp_r.valid <= req.valid;
    end
  end

  assign rsp = rsp_r;

endmodule

// ----- rtl/cexm_mac.sv -----
module cexm_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cexm_pkg::rd_rsp_t                rsp,
  input  logic                             acc_clr,
  output logic                             busy,
  output logic signed [cexm_pkg::RES_W-1:0] coulomb_sat,
  output logic signed [cexm_pkg::RES_W-1:0] exchange_sat
);
  import cexm_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = 64'shFFFF_8000_0000_0000;

  logic                    v_r;
  logic                    wj_r;
  logic                    dbl_r;
  logic signed [ACC_W-1:0] prod_j_r;
  logic signed [ACC_W-1:0] prod_k_r;
  logic signed [ACC_W-1:0] acc_j_r;
  logic signed [ACC_W-1:0] acc_k_r;
  logic signed [ACC_W-1:0] acc_j_nxt;
  logic signed [ACC_W-1:0] acc_k_nxt;
  logic signed [ACC_W-1:0] term_j;
  logic signed [ACC_W-1:0] term_k;
  logic signed [ACC_W-1:0] prod_j;
  logic signed [ACC_W-1:0] prod_k;

  assign prod_j = rsp.data_j * rsp.data_d;
  assign prod_k = rsp.data_k * rsp.data_d;

  always_ff @(posedge clk) begin
    prod_j_r <= prod_j;
    prod_k_r <= prod_k;
    wj_r     <= rsp.wj;
    dbl_r    <= rsp.dbl;
  end

  // The arithmetic shift drops the low fraction bits, which rounds toward minus infinity.
  always_comb begin
    term_j = prod_j_r >>> FRAC_W;
    term_k = prod_k_r >>> FRAC_W;
    if (dbl_r) begin
      term_j = term_j <<< 1;
    end
    acc_j_nxt = acc_j_r;
    acc_k_nxt = acc_k_r;
    if (acc_clr) begin
      acc_j_nxt = '0;
      acc_k_nxt = '0;
    end else if (v_r) begin
      acc_k_nxt = acc_k_r + term_k;
      if (wj_r) begin
        acc_j_nxt = acc_j_r + term_j;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      acc_j_r <= '0;
      acc_k_r <= '0;
    end else begin
      v_r     <= rsp.valid;
      acc_j_r <= acc_j_nxt;
      acc_k_r <= acc_k_nxt;
    end
  end

  assign busy = rsp.valid || v_r;

  always_comb begin
    if (acc_j_r > SAT_HI) begin
      coulomb_sat = SAT_HI[RES_W-1:0];
    end else if (acc_j_r < SAT_LO) begin
      coulomb_sat = SAT_LO[RES_W-1:0];
    end else begin
      coulomb_sat = acc_j_r[RES_W-1:0];
    end
    if (acc_k_r > SAT_HI) begin
      exchange_sat = SAT_HI[RES_W-1:0];
    end else if (acc_k_r < SAT_LO) begin
      exchange_sat = SAT_LO[RES_W-1:0];
    end else begin
      exchange_sat = acc_k_r[RES_W-1:0];
    end
  end

endmodule

// ----- rtl/cexm_seq.sv -----
`include "assert_macros.svh"

module cexm_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cexm_pkg::CFG_W-1:0]   cfg_dim,
  input  logic                         start,
  input  logic                         pipe_busy,
  input  logic                         out_free,
  output logic                         idle,
  output cexm_pkg::rd_req_t            req,
  output cexm_pkg::emit_t              emit
);
  import cexm_pkg::*;

  seq_state_t    state_r, state_nxt;
  logic [IW-1:0] p_r, p_nxt;
  logic [IW-1:0] q_r, q_nxt;
  logic [IW-1:0] r_r, r_nxt;
  logic [IW-1:0] s_r, s_nxt;
  logic [IW-1:0] dim_m1;
  logic          is_last;

  always_comb begin
    if (cfg_dim == '0) begin
      dim_m1 = '0;
    end else if (cfg_dim > CFG_W'(MAX_DIM)) begin
      dim_m1 = IW'(MAX_DIM - 1);
    end else begin
      dim_m1 = IW'(cfg_dim - CFG_W'(1));
    end
  end

  assign is_last = (p_r == dim_m1) && (q_r == p_r);

  always_comb begin
    state_nxt   = state_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    r_nxt       = r_r;
    s_nxt       = s_r;
    idle        = 1'b0;
    req.valid   = 1'b0;
    req.iaddr_j = iaddr(p_r, q_r, r_r, s_r);
    req.iaddr_k = iaddr(p_r, r_r, q_r, s_r);
    req.daddr   = daddr(r_r, s_r);
    req.wj      = (s_r <= r_r);
    req.dbl     = (s_r < r_r);
    emit.valid  = 1'b0;
    emit.row    = ROW_W'(p_r);
    emit.col    = ROW_W'(q_r);
    emit.last   = is_last;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          state_nxt = ST_RUN;
          p_nxt     = '0;
          q_nxt     = '0;
          r_nxt     = '0;
          s_nxt     = '0;
        end
      end
      ST_RUN: begin
        req.valid = 1'b1;
        if (s_r == dim_m1) begin
          s_nxt = '0;
          if (r_r == dim_m1) begin
            r_nxt     = '0;
            state_nxt = ST_DRAIN;
          end else begin
            r_nxt = r_r + IW'(1);
          end
        end else begin
          s_nxt = s_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit.valid = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
            p_nxt     = '0;
            q_nxt     = '0;
          end else begin
            state_nxt = ST_RUN;
            if (q_r == p_r) begin
              p_nxt = p_r + IW'(1);
              q_nxt = '0;
            end else begin
              q_nxt = q_r + IW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      p_r     <= '0;
      q_r     <= '0;
      r_r     <= '0;
      s_r     <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      r_r     <= r_nxt;
      s_r     <= s_nxt;
    end
  end

  `CEXM_ASSERT_IMP(a_emit_slot_free, emit.valid, out_free, "emit while output slot is full")
  `CEXM_ASSERT_IMP(a_emit_drained, emit.valid, !pipe_busy, "emit before accumulation finished")
  `CEXM_ASSERT_NEXT(a_last_to_idle, emit.valid && emit.last, state_r == ST_IDLE, "no idle after last")
  `CEXM_ASSERT_IMP(a_col_le_row, emit.valid, emit.col <= emit.row, "column above row")

endmodule
